/* sv/hbp_pkg.sv */
// shared types, constants and helpers for the hybrid branch predictor
package hbp_pkg;

  // default table sizes, in index bits
  localparam int MAX_BIMODAL_BITS_DEF = 12;
  localparam int MAX_GSHARE_BITS_DEF  = 12;
  localparam int MAX_CHOOSER_BITS_DEF = 10;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE          = 3'd0,
    REG_BIMODAL_BITS  = 3'd1,
    REG_GSHARE_BITS   = 3'd2,
    REG_HISTORY_BITS  = 3'd3,
    REG_CHOOSER_BITS  = 3'd4
  } reg_idx_t;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // predictor modes, the undefined code behaves as bimodal
  localparam logic [1:0] MODE_BIMODAL = 2'd0;
  localparam logic [1:0] MODE_GSHARE  = 2'd1;
  localparam logic [1:0] MODE_HYBRID  = 2'd2;

  // counter reset values and saturation bounds
  localparam logic [1:0] PRED_CTR_INIT    = 2'd2;
  localparam logic [1:0] CHOOSER_CTR_INIT = 2'd1;
  localparam logic [1:0] CTR_MAX          = 2'd3;
  localparam logic [1:0] CTR_MIN          = 2'd0;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // write-back command to the counter tables
  typedef struct packed {
    logic       bim_we;
    logic [1:0] bim_val;
    logic       gsh_we;
    logic [1:0] gsh_val;
    logic       cho_we;
    logic [1:0] cho_val;
  } tbl_wr_t;

  // saturating 2-bit counter step
  function automatic logic [1:0] bump(input logic [1:0] c, input logic up);
    logic [1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

endpackage

/* sv/hbp_ifs.sv */
// valid/ready channels for branch items and prediction results

interface hbp_branch_if;
  logic        valid;
  logic        ready;
  logic [31:0] branch_address;
  logic        taken;

  modport source (output valid, branch_address, taken, input ready);
  modport sink   (input valid, branch_address, taken, output ready);
endinterface

interface hbp_result_if;
  logic valid;
  logic ready;
  logic predicted_taken;
  logic mispredicted;

  modport source (output valid, predicted_taken, mispredicted, input ready);
  modport sink   (input valid, predicted_taken, mispredicted, output ready);
endinterface

/* sv/hbp_tables.sv */
// bimodal, gshare and chooser counter memories with a clearing pass after reset
module hbp_tables #(
  parameter int BIM_W = hbp_pkg::MAX_BIMODAL_BITS_DEF,
  parameter int GSH_W = hbp_pkg::MAX_GSHARE_BITS_DEF,
  parameter int CHO_W = hbp_pkg::MAX_CHOOSER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [BIM_W-1:0] bim_raddr,
  input  logic [GSH_W-1:0] gsh_raddr,
  input  logic [CHO_W-1:0] cho_raddr,
  output logic [1:0]       bim_rdata,
  output logic [1:0]       gsh_rdata,
  output logic [1:0]       cho_rdata,
  input  logic [BIM_W-1:0] bim_waddr,
  input  logic [GSH_W-1:0] gsh_waddr,
  input  logic [CHO_W-1:0] cho_waddr,
  input  hbp_pkg::tbl_wr_t wr,
  output logic             clr_busy
);
  import hbp_pkg::*;

  localparam int BIM_DEPTH = 1 << BIM_W;
  localparam int GSH_DEPTH = 1 << GSH_W;
  localparam int CHO_DEPTH = 1 << CHO_W;
  localparam int MAX_BG    = (BIM_W > GSH_W) ? BIM_W : GSH_W;
  localparam int CLR_W     = (MAX_BG > CHO_W) ? MAX_BG : CHO_W;

  logic [1:0] bim_mem [BIM_DEPTH];
  logic [1:0] gsh_mem [GSH_DEPTH];
  logic [1:0] cho_mem [CHO_DEPTH];

  logic [CLR_W-1:0] clr_idx;

  // clearing pass, one entry of every table per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      clr_busy <= 1'b1;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == '1) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // bimodal table
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      bim_mem[clr_idx[BIM_W-1:0]] <= PRED_CTR_INIT;
    end else if (wr.bim_we) begin
      bim_mem[bim_waddr] <= wr.bim_val;
    end
    if (rd_en) begin
      bim_rdata <= bim_mem[bim_raddr];
    end
  end

  // gshare table
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      gsh_mem[clr_idx[GSH_W-1:0]] <= PRED_CTR_INIT;
    end else if (wr.gsh_we) begin
      gsh_mem[gsh_waddr] <= wr.gsh_val;
    end
    if (rd_en) begin
      gsh_rdata <= gsh_mem[gsh_raddr];
    end
  end

  // chooser table
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      cho_mem[clr_idx[CHO_W-1:0]] <= CHOOSER_CTR_INIT;
    end else if (wr.cho_we) begin
      cho_mem[cho_waddr] <= wr.cho_val;
    end
    if (rd_en) begin
      cho_rdata <= cho_mem[cho_raddr];
    end
  end

endmodule

/* sv/hybrid_branch_predictor.sv */
// hybrid bimodal/gshare branch predictor top level
//
// Usage:
//   branch channel (sink): one beat per conditional branch, carrying its byte
//   address and its actual outcome. result channel (source): one beat per
//   branch with the prediction made before the update and a mispredict flag.
//   An APB port holds mode, bimodal/gshare/chooser index widths and the
//   history length; write it only while no branch is in flight.
// Timing:
//   a branch is accepted in ST_IDLE, the counter memories return their
//   entries the next cycle in ST_UPDATE, where the counters are updated and
//   the result is loaded into the output register once that register is
//   free. The next branch is accepted back in ST_IDLE, after the update,
//   as set by the read-then-write of the registered counter memories.
// Reset:
//   registers go to mode bimodal, widths 12/12/8/10, history is zeroed, and
//   a clearing pass over 2**max(table index bits) entries (4096 by default)
//   loads every counter before the first branch is accepted.
// Stall:
//   a new branch is accepted while a result waits in the output register;
//   that branch then holds in the update step until the result is taken.
module hybrid_branch_predictor #(
  parameter int MAX_BIMODAL_BITS = hbp_pkg::MAX_BIMODAL_BITS_DEF,
  parameter int MAX_GSHARE_BITS  = hbp_pkg::MAX_GSHARE_BITS_DEF,
  parameter int MAX_CHOOSER_BITS = hbp_pkg::MAX_CHOOSER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  hbp_branch_if.sink                     branch,
  hbp_result_if.source                   result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hbp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hbp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hbp_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import hbp_pkg::*;

  localparam int BIM_W = MAX_BIMODAL_BITS;
  localparam int GSH_W = MAX_GSHARE_BITS;
  localparam int CHO_W = MAX_CHOOSER_BITS;

  // configuration registers
  logic [1:0] mode;
  logic [3:0] bimodal_index_bits;
  logic [3:0] gshare_index_bits;
  logic [3:0] history_bits;
  logic [3:0] chooser_index_bits;
  reg_idx_t   reg_sel;
  logic       cfg_wr;

  // control and item state
  state_t           state;
  state_t           state_next;
  logic             item_taken;
  logic [BIM_W-1:0] bim_idx;
  logic [GSH_W-1:0] gsh_idx;
  logic [CHO_W-1:0] cho_idx;
  logic [GSH_W-1:0] global_history;
  logic             out_valid;
  logic             out_pred;
  logic             out_miss;

  // index datapath
  logic [29:0]      addr;
  logic [29:0]      addr_sh;
  logic [3:0]       bb_eff;
  logic [3:0]       gb_eff;
  logic [3:0]       hb_eff;
  logic [3:0]       cb_eff;
  logic [3:0]       low_bits;
  logic [BIM_W-1:0] bim_mask;
  logic [GSH_W-1:0] hist_mask;
  logic [GSH_W-1:0] low_mask;
  logic [CHO_W-1:0] cho_mask;
  logic [GSH_W-1:0] hist_used;
  logic [GSH_W-1:0] upper;
  logic [BIM_W-1:0] bim_idx_next;
  logic [GSH_W-1:0] gsh_idx_next;
  logic [CHO_W-1:0] cho_idx_next;
  logic [GSH_W-1:0] hist_shifted;

  // update datapath
  logic [1:0] bim_ctr;
  logic [1:0] gsh_ctr;
  logic [1:0] cho_ctr;
  logic       bpred;
  logic       gpred;
  logic       pred;
  logic       accept;
  logic       do_update;
  logic       out_free;
  logic       shift_hist;
  logic       clr_busy;
  tbl_wr_t    wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_BIMODAL;
      bimodal_index_bits <= 4'd12;
      gshare_index_bits  <= 4'd12;
      history_bits       <= 4'd8;
      chooser_index_bits <= 4'd10;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_MODE:         mode               <= pwdata[1:0];
        REG_BIMODAL_BITS: bimodal_index_bits <= pwdata[3:0];
        REG_GSHARE_BITS:  gshare_index_bits  <= pwdata[3:0];
        REG_HISTORY_BITS: history_bits       <= pwdata[3:0];
        REG_CHOOSER_BITS: chooser_index_bits <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_MODE:         prdata = APB_DATA_W'(mode);
      REG_BIMODAL_BITS: prdata = APB_DATA_W'(bimodal_index_bits);
      REG_GSHARE_BITS:  prdata = APB_DATA_W'(gshare_index_bits);
      REG_HISTORY_BITS: prdata = APB_DATA_W'(history_bits);
      REG_CHOOSER_BITS: prdata = APB_DATA_W'(chooser_index_bits);
      default:          prdata = '0;
    endcase
  end

  // effective widths, clamped to the table sizes
  always_comb begin
    bb_eff = (int'(bimodal_index_bits) > BIM_W) ? 4'(BIM_W) : bimodal_index_bits;
    gb_eff = (int'(gshare_index_bits) > GSH_W) ? 4'(GSH_W) : gshare_index_bits;
    cb_eff = (int'(chooser_index_bits) > CHO_W) ? 4'(CHO_W) : chooser_index_bits;
    hb_eff = (history_bits > gb_eff) ? gb_eff : history_bits;
    low_bits = gb_eff - hb_eff;
    for (int i = 0; i < BIM_W; i++) bim_mask[i] = (i < int'(bb_eff));
    for (int i = 0; i < CHO_W; i++) cho_mask[i] = (i < int'(cb_eff));
    for (int i = 0; i < GSH_W; i++) begin
      hist_mask[i] = (i < int'(hb_eff));
      low_mask[i]  = (i < int'(low_bits));
    end
  end

  // table indexes from the incoming address
  always_comb begin
    addr         = branch.branch_address[31:2];
    addr_sh      = addr >> low_bits;
    hist_used    = global_history & hist_mask;
    upper        = (addr_sh[GSH_W-1:0] ^ hist_used) & hist_mask;
    bim_idx_next = addr[BIM_W-1:0] & bim_mask;
    gsh_idx_next = (upper << low_bits) | (addr[GSH_W-1:0] & low_mask);
    cho_idx_next = addr[CHO_W-1:0] & cho_mask;
  end

  // history shifted by the current outcome
  always_comb begin
    hist_shifted = (global_history & hist_mask) >> 1;
    for (int i = 0; i < GSH_W; i++) begin
      if (item_taken && (i == int'(hb_eff) - 1)) hist_shifted[i] = 1'b1;
    end
    hist_shifted = hist_shifted & hist_mask;
  end

  // handshake
  assign out_free     = !out_valid || result.ready;
  assign accept       = branch.valid && branch.ready;
  assign do_update    = (state == ST_UPDATE) && out_free;
  assign branch.ready = (state == ST_IDLE);
  assign result.valid           = out_valid;
  assign result.predicted_taken = out_pred;
  assign result.mispredicted    = out_miss;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (!clr_busy) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // prediction and counter write-back
  always_comb begin
    bpred      = bim_ctr[1];
    gpred      = gsh_ctr[1];
    wr         = '0;
    wr.bim_val = bump(bim_ctr, item_taken);
    wr.gsh_val = bump(gsh_ctr, item_taken);
    wr.cho_val = bump(cho_ctr, gpred == item_taken);
    shift_hist = 1'b0;
    pred       = bpred;
    unique case (mode)
      MODE_GSHARE: begin
        pred       = gpred;
        wr.gsh_we  = do_update;
        shift_hist = do_update;
      end
      MODE_HYBRID: begin
        pred       = cho_ctr[1] ? gpred : bpred;
        wr.gsh_we  = do_update && cho_ctr[1];
        wr.bim_we  = do_update && !cho_ctr[1];
        shift_hist = do_update;
        wr.cho_we  = do_update && (gpred != bpred);
      end
      default: begin
        pred      = bpred;
        wr.bim_we = do_update;
      end
    endcase
  end

  // item registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_taken <= branch.taken;
      bim_idx    <= bim_idx_next;
      gsh_idx    <= gsh_idx_next;
      cho_idx    <= cho_idx_next;
    end
  end

  // global history
  always_ff @(posedge clk) begin
    if (rst) begin
      global_history <= '0;
    end else if (shift_hist) begin
      global_history <= hist_shifted;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_update) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      out_pred <= pred;
      out_miss <= pred ^ item_taken;
    end
  end

  hbp_tables #(
    .BIM_W (BIM_W),
    .GSH_W (GSH_W),
    .CHO_W (CHO_W)
  ) u_tables (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .bim_raddr (bim_idx_next),
    .gsh_raddr (gsh_idx_next),
    .cho_raddr (cho_idx_next),
    .bim_rdata (bim_ctr),
    .gsh_rdata (gsh_ctr),
    .cho_rdata (cho_ctr),
    .bim_waddr (bim_idx),
    .gsh_waddr (gsh_idx),
    .cho_waddr (cho_idx),
    .wr        (wr),
    .clr_busy  (clr_busy)
  );

endmodule

/* sv/hbp_checker.sv */
// port-level checks for the hybrid branch predictor, bound to the top level
module hbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        branch_valid,
  input logic        branch_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic        predicted_taken,
  input logic        mispredicted,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // reset starts the clearing pass, no branch taken right after it
  a_reset_blocks: assert property (@(posedge clk) rst |=> !branch_ready)
    else $error("branch ready right after reset");

  // one branch in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (branch_valid && branch_ready) |=> !branch_ready)
    else $error("second branch accepted while one is in flight");

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(predicted_taken) && $stable(mispredicted)))
    else $error("stalled result beat changed");

  // mode register reads back what was written
  a_mode_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && (paddr == 5'd0)) |=>
      ((paddr != 5'd0) || (prdata[1:0] == $past(pwdata[1:0]))))
    else $error("mode register read back wrong");

endmodule

bind hybrid_branch_predictor hbp_checker u_hbp_checker (
  .clk             (clk),
  .rst             (rst),
  .branch_valid    (branch.valid),
  .branch_ready    (branch.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .predicted_taken (result.predicted_taken),
  .mispredicted    (result.mispredicted),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);
